@@ hw/rtl/rcfb_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the RC control frame builder.
// No dependencies; every other file refers to it by scoped names.
package rcfb_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN   = 12;
    localparam int unsigned NUM_CH      = 4;
    localparam logic [7:0]  SYNC_BYTE   = 8'hA5;
    localparam logic [7:0]  FLAGS_BYTE  = 8'h00;
    localparam logic [7:0]  CRC_POLY    = 8'h8C;

    // Byte positions within the frame
    localparam logic [3:0]  BYTE_SYNC   = 4'd0;
    localparam logic [3:0]  BYTE_SEQ    = 4'd1;
    localparam logic [3:0]  BYTE_FLAGS  = 4'd2;
    localparam logic [3:0]  BYTE_CH0    = 4'd3;
    localparam logic [3:0]  BYTE_CRC    = 4'd11;

    // Pulse width limits and channel scaling
    localparam logic signed [15:0] US_MIN = 16'sd1000;
    localparam logic signed [15:0] US_MAX = 16'sd2000;
    localparam logic [9:0]  OFF_SPAN    = 10'd1000;
    // 2047 = 2*1000 + 47, so only off*47 needs a divide by 1000
    localparam logic [5:0]  SCALE_REM   = 6'd47;
    // floor(x/1000) = (x * 67109) >> 26, exact for x below 490000
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam int unsigned RECIP_SHIFT = 26;

    // Queue depth between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [15:0] roll_us;
        logic signed [15:0] pitch_us;
        logic signed [15:0] yaw_us;
        logic signed [15:0] throttle_us;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_index;
        logic       last_byte;
    } out_item_t;

    // One classified frame: sequence count and the four scaled channels
    typedef struct packed {
        logic [7:0]             seq;
        logic [3:0][10:0]       ch;
    } frame_desc_t;

    // Reflected CRC-8 update with one byte, LSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       fb;
        crc = crc_in;
        b   = data;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ b[0];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

@@ hw/rtl/rcfb_front.sv @@
// Front end: accepts stick words, clamps and scales them in two stages, tags the sequence count.
// Depends on rcfb_pkg.
module rcfb_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rcfb_pkg::in_item_t   s_payload,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rcfb_pkg::frame_desc_t push_desc
);

    logic                 s1_valid_reg, s1_valid_next;
    logic [3:0][9:0]      s1_off_reg,   s1_off_next;
    logic [3:0][15:0]     s1_prod_reg,  s1_prod_next;
    logic [7:0]           s1_seq_reg,   s1_seq_next;
    logic                 s2_valid_reg, s2_valid_next;
    rcfb_pkg::frame_desc_t s2_desc_reg, s2_desc_next;
    logic [7:0]           seq_reg,      seq_next;

    logic                 s1_ready;
    logic                 s2_ready;
    logic signed [15:0]   us_lane [4];
    logic signed [15:0]   us_diff [4];
    logic [32:0]          quot_full [4];

    assign s2_ready   = !s2_valid_reg || push_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign s_ready    = s1_ready;
    assign push_valid = s2_valid_reg;
    assign push_desc  = s2_desc_reg;

    // Lane order matches the frame: roll, pitch, yaw, throttle
    assign us_lane[0] = s_payload.roll_us;
    assign us_lane[1] = s_payload.pitch_us;
    assign us_lane[2] = s_payload.yaw_us;
    assign us_lane[3] = s_payload.throttle_us;

    // Stage 1: clamp to the pulse range and form off*47
    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_off_next   = s1_off_reg;
        s1_prod_next  = s1_prod_reg;
        s1_seq_next   = s1_seq_reg;
        seq_next      = seq_reg;
        for (int c = 0; c < 4; c++) begin
            us_diff[c] = us_lane[c] - rcfb_pkg::US_MIN;
        end
        if (s1_ready) begin
            s1_valid_next = s_valid;
            if (s_valid) begin
                s1_seq_next = seq_reg;
                seq_next    = seq_reg + 8'd1;
                for (int c = 0; c < 4; c++) begin
                    if (us_lane[c] < rcfb_pkg::US_MIN) begin
                        s1_off_next[c] = 10'd0;
                    end else if (us_lane[c] > rcfb_pkg::US_MAX) begin
                        s1_off_next[c] = rcfb_pkg::OFF_SPAN;
                    end else begin
                        s1_off_next[c] = us_diff[c][9:0];
                    end
                    s1_prod_next[c] = {6'd0, s1_off_next[c]} * {10'd0, rcfb_pkg::SCALE_REM};
                end
            end
        end
    end

    // Stage 2: divide the remainder term by 1000 and add twice the offset
    always_comb begin
        s2_valid_next = s2_valid_reg;
        s2_desc_next  = s2_desc_reg;
        for (int c = 0; c < 4; c++) begin
            quot_full[c] = {17'd0, s1_prod_reg[c]} * {16'd0, rcfb_pkg::RECIP_1000};
        end
        if (s2_ready) begin
            s2_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                s2_desc_next.seq = s1_seq_reg;
                for (int c = 0; c < 4; c++) begin
                    s2_desc_next.ch[c] = {s1_off_reg[c], 1'b0}
                                       + 11'(quot_full[c] >> rcfb_pkg::RECIP_SHIFT);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            seq_reg      <= 8'd0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            seq_reg      <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_off_reg  <= s1_off_next;
        s1_prod_reg <= s1_prod_next;
        s1_seq_reg  <= s1_seq_next;
        s2_desc_reg <= s2_desc_next;
    end

endmodule

@@ hw/rtl/rcfb_queue.sv @@
// Short FIFO of frame descriptors between the front end and the serializer.
// Depends on rcfb_pkg.
module rcfb_queue #(
    parameter int unsigned DEPTH = rcfb_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rcfb_pkg::frame_desc_t push_desc,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output rcfb_pkg::frame_desc_t pop_desc
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rcfb_pkg::frame_desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with explicit wrap and track the fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

@@ hw/rtl/rcfb_back.sv @@
// Serializer: walks one descriptor out as 12 bytes, building the CRC-8 as bytes leave.
// Depends on rcfb_pkg.
module rcfb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  rcfb_pkg::frame_desc_t pop_desc,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rcfb_pkg::out_item_t   m_payload
);

    logic                  busy_reg,    busy_next;
    logic [3:0]            idx_reg,     idx_next;
    rcfb_pkg::frame_desc_t desc_reg,    desc_next;
    logic [7:0]            crc_reg,     crc_next;
    logic                  m_valid_reg, m_valid_next;
    rcfb_pkg::out_item_t   m_payload_reg, m_payload_next;

    logic       advance;
    logic       at_last;
    logic [3:0] lane;
    logic [15:0] ch_word;
    logic [7:0] byte_val;
    logic [7:0] crc_base;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign at_last   = (idx_reg == rcfb_pkg::BYTE_CRC);
    assign pop_ready = !busy_reg || (advance && at_last);

    // Select the byte for the current position
    always_comb begin
        lane    = idx_reg - rcfb_pkg::BYTE_CH0;
        ch_word = {5'd0, desc_reg.ch[lane[2:1]]};
        unique case (idx_reg)
            rcfb_pkg::BYTE_SYNC:  byte_val = rcfb_pkg::SYNC_BYTE;
            rcfb_pkg::BYTE_SEQ:   byte_val = desc_reg.seq;
            rcfb_pkg::BYTE_FLAGS: byte_val = rcfb_pkg::FLAGS_BYTE;
            rcfb_pkg::BYTE_CRC:   byte_val = crc_reg;
            default:              byte_val = lane[0] ? ch_word[7:0] : ch_word[15:8];
        endcase
        crc_base = (idx_reg == rcfb_pkg::BYTE_SYNC) ? 8'd0 : crc_reg;
    end

    // Emit a byte, drop the output when taken, load the next descriptor
    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        desc_next      = desc_reg;
        crc_next       = crc_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (advance) begin
            m_valid_next              = 1'b1;
            m_payload_next.frame_byte = byte_val;
            m_payload_next.byte_index = idx_reg;
            m_payload_next.last_byte  = at_last;
            idx_next                  = idx_reg + 4'd1;
            crc_next                  = rcfb_pkg::crc8_update(crc_base, byte_val);
            if (at_last) begin
                busy_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop_valid && pop_ready) begin
            desc_next = pop_desc;
            busy_next = 1'b1;
            idx_next  = rcfb_pkg::BYTE_SYNC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= rcfb_pkg::BYTE_SYNC;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg      <= desc_next;
        crc_reg       <= crc_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

@@ hw/rtl/rc_control_frame_builder_core.sv @@
// Top level of the RC control frame builder: front end, descriptor queue, serializer.
// Depends on rcfb_pkg, rcfb_front, rcfb_queue and rcfb_back.
//
// Usage:
//   s_* channel takes one word of four stick pulse widths (signed microseconds).
//   Each width is clamped to 1000..2000 and scaled to an 11-bit channel.
//   m_* channel returns the 12-byte frame one byte per word: sync 0xA5,
//   sequence count, flags 0x00, roll/pitch/yaw/throttle big-endian, CRC-8.
//   last_byte marks the CRC byte at index 11.
// Throughput: set by the serializer sending one byte per cycle while m_ready
//   stays high; the front end accepts new words while a frame goes out,
//   until the descriptor queue (QUEUE_DEPTH entries) and its two stages fill.
// Reset: aresetn synchronous, active low; clears all valid flags and the
//   sequence count to zero.
// Stall: with m_ready low the output byte holds; the serializer and then the
//   queue and front end fill and s_ready drops.
module rc_control_frame_builder_core #(
    parameter int unsigned QUEUE_DEPTH = rcfb_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rcfb_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output rcfb_pkg::out_item_t m_payload
);

    logic                  push_valid, push_ready;
    rcfb_pkg::frame_desc_t push_desc;
    logic                  pop_valid,  pop_ready;
    rcfb_pkg::frame_desc_t pop_desc;

    rcfb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_payload  (s_payload),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    rcfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    rcfb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ hw/rtl/rcfb_checker.sv @@
// Port-level checks on the frame stream of the RC control frame builder, bound to the top.
// Depends on rcfb_pkg and rc_control_frame_builder_core.
module rcfb_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rcfb_pkg::out_item_t m_payload
);

    // A stalled output byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("output byte changed while stalled");

    // Every frame opens with the sync byte
    a_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_payload.byte_index == rcfb_pkg::BYTE_SYNC)
        |-> (m_payload.frame_byte == rcfb_pkg::SYNC_BYTE))
        else $error("frame does not open with sync byte");

    // The last marker sits on the CRC position and nowhere else
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.last_byte == (m_payload.byte_index == rcfb_pkg::BYTE_CRC)))
        else $error("last marker mismatch");

    // Within a frame the next byte shown follows the one just taken
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_payload.last_byte
        |=> !m_valid || (m_payload.byte_index == $past(m_payload.byte_index) + 4'd1))
        else $error("byte index out of sequence");

endmodule

bind rc_control_frame_builder_core rcfb_checker u_rcfb_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

@@ tb/tb_rc_control_frame_builder_core.sv @@
// Self-checking testbench for rc_control_frame_builder_core: drives stick words,
// predicts each 12-byte control frame and checks every byte that comes out.
// Depends on rcfb_pkg and the rc_control_frame_builder_core RTL only.
module tb_rc_control_frame_builder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 9;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_DIRECTED = 15;
    localparam int NUM_PHASE1   = 90;
    localparam int NUM_PHASE2   = 80;
    localparam int NUM_PHASE3   = 80;

    // Predicts control frames and holds the bytes still owed by the block
    class frame_scoreboard;
        rcfb_pkg::out_item_t expected_bytes[$];
        logic [7:0]          seq_count;
        int                  errors;

        function new();
            seq_count = 8'd0;
            errors    = 0;
        endfunction

        // Clamp a pulse width to the stick range and scale it to 11 bits
        function logic [10:0] stick_to_channel(logic signed [15:0] us);
            int v;
            v = us;
            if (v < rcfb_pkg::US_MIN) begin
                v = rcfb_pkg::US_MIN;
            end
            if (v > rcfb_pkg::US_MAX) begin
                v = rcfb_pkg::US_MAX;
            end
            return 11'(((v - rcfb_pkg::US_MIN) * 2047) / 1000);
        endfunction

        // Build the frame for one accepted word and queue its bytes
        function void note_word(rcfb_pkg::in_item_t w);
            logic [7:0]          frame [rcfb_pkg::FRAME_LEN];
            logic signed [15:0]  sticks [rcfb_pkg::NUM_CH];
            logic [10:0]         ch;
            logic [7:0]          crc;
            logic [7:0]          b;
            logic                fb;
            rcfb_pkg::out_item_t e;
            sticks[0] = w.roll_us;
            sticks[1] = w.pitch_us;
            sticks[2] = w.yaw_us;
            sticks[3] = w.throttle_us;
            frame[rcfb_pkg::BYTE_SYNC]  = rcfb_pkg::SYNC_BYTE;
            frame[rcfb_pkg::BYTE_SEQ]   = seq_count;
            frame[rcfb_pkg::BYTE_FLAGS] = rcfb_pkg::FLAGS_BYTE;
            for (int c = 0; c < rcfb_pkg::NUM_CH; c++) begin
                ch = stick_to_channel(sticks[c]);
                frame[rcfb_pkg::BYTE_CH0 + 2 * c]     = {5'b0, ch[10:8]};
                frame[rcfb_pkg::BYTE_CH0 + 2 * c + 1] = ch[7:0];
            end
            // Reflected CRC-8, LSB first, over everything but the last byte
            crc = 8'd0;
            for (int k = 0; k < rcfb_pkg::BYTE_CRC; k++) begin
                b = frame[k];
                for (int i = 0; i < 8; i++) begin
                    fb  = crc[0] ^ b[0];
                    crc = crc >> 1;
                    if (fb) begin
                        crc = crc ^ rcfb_pkg::CRC_POLY;
                    end
                    b = b >> 1;
                end
            end
            frame[rcfb_pkg::BYTE_CRC] = crc;
            seq_count = seq_count + 8'd1;
            for (int k = 0; k < rcfb_pkg::FRAME_LEN; k++) begin
                e.frame_byte = frame[k];
                e.byte_index = 4'(k);
                e.last_byte  = (k == rcfb_pkg::BYTE_CRC);
                expected_bytes.push_back(e);
            end
        endfunction

        // Compare one output byte against the oldest expectation
        function void check_byte(rcfb_pkg::out_item_t got);
            rcfb_pkg::out_item_t want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected byte, expected none, actual %h idx %0d last %b",
                         $time, got.frame_byte, got.byte_index, got.last_byte);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte) begin
                errors++;
                $display("%0t: frame_byte at idx %0d: expected %h, actual %h",
                         $time, want.byte_index, want.frame_byte, got.frame_byte);
            end
            if (got.byte_index !== want.byte_index) begin
                errors++;
                $display("%0t: byte_index: expected %0d, actual %0d",
                         $time, want.byte_index, got.byte_index);
            end
            if (got.last_byte !== want.last_byte) begin
                errors++;
                $display("%0t: last_byte at idx %0d: expected %b, actual %b",
                         $time, want.byte_index, want.last_byte, got.last_byte);
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    rcfb_pkg::in_item_t  s_payload;
    logic                m_valid;
    logic                m_ready;
    rcfb_pkg::out_item_t m_payload;

    frame_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_left;
    int quiet_cycles;

    // Corner widths: range limits, clamp edges, negatives and bit patterns
    int directed_us [NUM_DIRECTED][4] = '{
        '{-32768, -32768, -32768, -32768},
        '{32767, 32767, 32767, 32767},
        '{999, 999, 999, 999},
        '{1000, 1000, 1000, 1000},
        '{1001, 1001, 1001, 1001},
        '{1999, 1999, 1999, 1999},
        '{2000, 2000, 2000, 2000},
        '{2001, 2001, 2001, 2001},
        '{0, 0, 0, 0},
        '{-1, -1, -1, -1},
        '{1000, 2000, 1500, 1234},
        '{2000, 1000, -500, 3000},
        '{1500, 1500, 1500, 1500},
        '{21845, -21846, 21845, -21846},
        '{-21846, 21845, -21846, 21845}
    };

    rc_control_frame_builder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watch both channels at each edge; feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_word(s_payload);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_byte(m_payload);
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive ready on the output side; a long hold-off backs the block up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one word, with random idle cycles ahead of it, and hold until taken
    task automatic send_word(input rcfb_pkg::in_item_t w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Mostly widths near the stick range, the rest anywhere in 16 bits
    function automatic logic signed [15:0] random_width();
        if ($urandom_range(0, 9) < 6) begin
            return 16'($urandom_range(900, 2100));
        end
        return 16'($urandom);
    endfunction

    task automatic send_random(input int count);
        rcfb_pkg::in_item_t w;
        for (int i = 0; i < count; i++) begin
            w.roll_us     = random_width();
            w.pitch_us    = random_width();
            w.yaw_us      = random_width();
            w.throttle_us = random_width();
            send_word(w);
        end
    endtask

    initial begin
        rcfb_pkg::in_item_t w;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_payload    = '0;
        m_ready      = 1'b0;
        quiet_cycles = 0;
        hold_left    = 0;
        tx_idle_pct  = 26;
        rx_idle_pct  = 86;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Corner words, then random ones; slow receiver first
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            w.roll_us     = 16'(directed_us[i][0]);
            w.pitch_us    = 16'(directed_us[i][1]);
            w.yaw_us      = 16'(directed_us[i][2]);
            w.throttle_us = 16'(directed_us[i][3]);
            send_word(w);
        end
        send_random(NUM_PHASE1);

        // Slow sender, quick receiver
        tx_idle_pct = 86;
        rx_idle_pct = 26;
        send_random(NUM_PHASE2);

        // Full rate both sides, opening with a long receiver hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_left   = HOLD_CYCLES;
        send_random(NUM_PHASE3);
        s_valid <= 1'b0;

        // Drain, then let a few more cycles pass for stray bytes
        while (sb.expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
